// ===== sv/sqt_pkg.sv =====
// ----------------------------------------------------------------------------
// sqt_pkg
// shared types and codes of the sorted timer queue
// ----------------------------------------------------------------------------
package sqt_pkg;

	localparam int ID_W       = 4;
	localparam int TIME_W     = 64;
	localparam int IN_DELTA_W = 32;

	// item kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_STOP  = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	// cell operations
	localparam logic [2:0] CELL_HOLD   = 3'd0;
	localparam logic [2:0] CELL_MARK   = 3'd1;
	localparam logic [2:0] CELL_SHIFT  = 3'd2;
	localparam logic [2:0] CELL_POP    = 3'd3;
	localparam logic [2:0] CELL_INSERT = 3'd4;

	typedef struct packed {
		logic [1:0]            kind;
		logic [ID_W-1:0]       timer_id;
		logic [IN_DELTA_W-1:0] delta;
		logic                  repetitive;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0]   fired_id;
		logic [TIME_W-1:0] fire_time;
		logic              rearmed;
		logic              last;
	} result_t;

	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] deadline;
		logic [ID_W-1:0]   owner;
	} cell_data_t;

	typedef struct packed {
		logic [2:0]        op;
		logic [TIME_W-1:0] new_deadline;
		logic [ID_W-1:0]   new_owner;
		logic [ID_W-1:0]   match_id;
	} cell_cmd_t;

	localparam cell_data_t EMPTY_CELL = '{valid: 1'b0, deadline: '0, owner: '0};

endpackage

// ===== sv/sqt_ram.sv =====
// ----------------------------------------------------------------------------
// sqt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sqt_ram #(
	parameter int WIDTH  = 33,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== sv/sqt_cell.sv =====
// ----------------------------------------------------------------------------
// sqt_cell
// one slot of the sorted timer chain
// ----------------------------------------------------------------------------
module sqt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sqt_pkg::cell_cmd_t  cmd,
	input  sqt_pkg::cell_data_t prev_data,
	input  sqt_pkg::cell_data_t next_data,
	input  logic                prev_gt,
	input  logic                prev_hole,
	output sqt_pkg::cell_data_t data,
	output logic                gt,
	output logic                hole
);

	import sqt_pkg::*;

	logic              valid_q;
	logic [TIME_W-1:0] deadline_q;
	logic [ID_W-1:0]   owner_q;
	logic              hole_q;

	assign data = '{valid: valid_q, deadline: deadline_q, owner: owner_q};
	assign hole = hole_q;

	// new deadline goes before this cell
	assign gt = !valid_q || (deadline_q > cmd.new_deadline);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hole_q  <= 1'b0;
		end else begin
			case (cmd.op)
				CELL_MARK: begin
					hole_q <= valid_q && (owner_q == cmd.match_id);
				end
				CELL_SHIFT: begin
					if (hole_q) begin
						valid_q <= next_data.valid;
					end
					hole_q <= prev_hole && valid_q;
				end
				CELL_POP: begin
					valid_q <= next_data.valid;
				end
				CELL_INSERT: begin
					if (prev_gt) begin
						valid_q <= prev_data.valid;
					end else if (gt) begin
						valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_SHIFT: begin
				if (hole_q) begin
					deadline_q <= next_data.deadline;
					owner_q    <= next_data.owner;
				end
			end
			CELL_POP: begin
				deadline_q <= next_data.deadline;
				owner_q    <= next_data.owner;
			end
			CELL_INSERT: begin
				if (prev_gt) begin
					deadline_q <= prev_data.deadline;
					owner_q    <= prev_data.owner;
				end else if (gt) begin
					deadline_q <= cmd.new_deadline;
					owner_q    <= cmd.new_owner;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== sv/sorted_timer_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_timer_queue_top
// deadline-ordered queue of timers kept in a chain of sorted cells
// ----------------------------------------------------------------------------
// usage
//   item channel (item_valid / item_ready / item) takes one word per item:
//   start arms a timer at now plus delta, stop removes it, tick advances the
//   64-bit time count and reports every due timer on the result channel
//   (result_valid / result_ready / result), one word per expiry, in deadline
//   order, ties in queue order, last set on the final word of the tick
//   item_ready is high only while the sequencer is idle, one item at a time
//   start / stop: accept, mark the owner's cell, then shift while the hole
//   travels cell by cell to close the gap (up to NUM_TIMERS cells) until it
//   is seen closed, then one insert for a start
//   tick: with nothing due, check and back to idle; else per expiry check
//   and pop the head, read the period ram, re-insert when it repeats, up to
//   NUM_TIMERS expiries; each word is written out at the following check
//   a result word waits in the output register; a stalled receiver holds
//   the sequencer only when the next word has to be written
//   reset empties the queue and clears the time count; the period ram is
//   never cleared, it is read only for timers that were started
// ----------------------------------------------------------------------------
module sorted_timer_queue_top #(
	parameter int NUM_TIMERS = 16,
	parameter int DELTA_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  sqt_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output sqt_pkg::result_t result
);

	import sqt_pkg::*;

	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW = $clog2(NUM_TIMERS + 1);
	localparam int RW = DELTA_BITS + 1;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MARK   = 3'd1;
	localparam logic [2:0] ST_SHIFT  = 3'd2;
	localparam logic [2:0] ST_INSERT = 3'd3;
	localparam logic [2:0] ST_CHECK  = 3'd4;
	localparam logic [2:0] ST_READ   = 3'd5;

	logic [2:0]        state_q;
	logic [TIME_W-1:0] now_q;
	logic [ID_W-1:0]   id_q;
	logic              is_start_q;
	logic [TIME_W-1:0] ins_dl_q;
	logic [ID_W-1:0]   ins_owner_q;
	logic              ret_tick_q;
	logic [CW-1:0]     count_q;
	logic [ID_W-1:0]   hd_owner_q;
	logic [TIME_W-1:0] hd_dl_q;
	logic              pend_v_q;
	logic [ID_W-1:0]   pend_id_q;
	logic              pend_re_q;
	logic              out_v_q;
	result_t           out_q;

	cell_cmd_t  cmd;
	cell_data_t cell_d    [NUM_TIMERS];
	cell_data_t prev_d    [NUM_TIMERS];
	cell_data_t next_d    [NUM_TIMERS];
	logic       cell_gt   [NUM_TIMERS];
	logic       cell_hole [NUM_TIMERS];
	logic       prev_gt   [NUM_TIMERS];
	logic       prev_hole [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] hole_vec;

	// chain of cells, cell 0 is the head
	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign prev_d[i]    = EMPTY_CELL;
			assign prev_gt[i]   = 1'b0;
			assign prev_hole[i] = 1'b0;
		end else begin : g_mid
			assign prev_d[i]    = cell_d[i-1];
			assign prev_gt[i]   = cell_gt[i-1];
			assign prev_hole[i] = cell_hole[i-1];
		end
		if (i == NUM_TIMERS - 1) begin : g_last
			assign next_d[i] = EMPTY_CELL;
		end else begin : g_inner
			assign next_d[i] = cell_d[i+1];
		end
		assign hole_vec[i] = cell_hole[i];

		sqt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.prev_data (prev_d[i]),
			.next_data (next_d[i]),
			.prev_gt   (prev_gt[i]),
			.prev_hole (prev_hole[i]),
			.data      (cell_d[i]),
			.gt        (cell_gt[i]),
			.hole      (cell_hole[i])
		);
	end

	// input decode
	logic              item_acc;
	logic              id_ok;
	logic [TIME_W-1:0] delta_ext;
	logic [DELTA_BITS-1:0] delta_m;

	assign item_ready = (state_q == ST_IDLE);
	assign item_acc   = item_valid && item_ready;
	assign id_ok      = (32'(item.timer_id) < NUM_TIMERS);
	assign delta_ext  = TIME_W'(item.delta);
	assign delta_m    = delta_ext[DELTA_BITS-1:0];

	// period / repeat store, indexed by timer id
	logic          ram_we;
	logic [RW-1:0] ram_rd;

	assign ram_we = item_acc && (item.kind == KIND_START) && id_ok;

	sqt_ram #(
		.WIDTH (RW),
		.DEPTH (NUM_TIMERS)
	) u_period_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (AW'(item.timer_id)),
		.wr_data ({item.repetitive, delta_m}),
		.rd_addr (AW'(cell_d[0].owner)),
		.rd_data (ram_rd)
	);

	logic [DELTA_BITS-1:0] period;
	assign period = (ram_rd[DELTA_BITS-1:0] == '0) ? DELTA_BITS'(1) : ram_rd[DELTA_BITS-1:0];

	// head due check and output handshake
	logic fire;
	logic can_out;
	logic emit;
	logic emit_last;

	assign fire    = (32'(count_q) < NUM_TIMERS) && cell_d[0].valid
	                 && (cell_d[0].deadline <= now_q);
	assign can_out = !out_v_q || result_ready;

	always_comb begin
		emit      = 1'b0;
		emit_last = 1'b0;
		cmd.op           = CELL_HOLD;
		cmd.new_deadline = ins_dl_q;
		cmd.new_owner    = ins_owner_q;
		cmd.match_id     = id_q;
		case (state_q)
			ST_MARK: begin
				cmd.op = CELL_MARK;
			end
			ST_SHIFT: begin
				if (|hole_vec) begin
					cmd.op = CELL_SHIFT;
				end
			end
			ST_INSERT: begin
				// full chain cannot take another entry
				if (!cell_d[NUM_TIMERS-1].valid) begin
					cmd.op = CELL_INSERT;
				end
			end
			ST_CHECK: begin
				if (fire) begin
					if (!pend_v_q || can_out) begin
						cmd.op = CELL_POP;
						emit   = pend_v_q;
					end
				end else if (pend_v_q && can_out) begin
					emit      = 1'b1;
					emit_last = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			now_q      <= '0;
			count_q    <= '0;
			pend_v_q   <= 1'b0;
			ret_tick_q <= 1'b0;
			is_start_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						if (item.kind == KIND_TICK) begin
							now_q    <= now_q + TIME_W'(1);
							count_q  <= '0;
							pend_v_q <= 1'b0;
							state_q  <= ST_CHECK;
						end else if ((item.kind == KIND_START || item.kind == KIND_STOP)
						             && id_ok) begin
							is_start_q <= (item.kind == KIND_START);
							ret_tick_q <= 1'b0;
							state_q    <= ST_MARK;
						end
					end
				end
				ST_MARK: begin
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (!(|hole_vec)) begin
						state_q <= is_start_q ? ST_INSERT : ST_IDLE;
					end
				end
				ST_INSERT: begin
					state_q <= ret_tick_q ? ST_CHECK : ST_IDLE;
				end
				ST_CHECK: begin
					if (fire) begin
						if (!pend_v_q || can_out) begin
							count_q  <= count_q + CW'(1);
							pend_v_q <= 1'b0;
							state_q  <= ST_READ;
						end
					end else if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (can_out) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				ST_READ: begin
					pend_v_q <= 1'b1;
					if (ram_rd[DELTA_BITS]) begin
						ret_tick_q <= 1'b1;
						state_q    <= ST_INSERT;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers of the sequencer
	always_ff @(posedge clk) begin
		if (item_acc) begin
			id_q        <= item.timer_id;
			ins_owner_q <= item.timer_id;
			ins_dl_q    <= now_q + TIME_W'(delta_m);
		end
		if (state_q == ST_CHECK && cmd.op == CELL_POP) begin
			hd_owner_q <= cell_d[0].owner;
			hd_dl_q    <= cell_d[0].deadline;
		end
		if (state_q == ST_READ) begin
			pend_id_q   <= hd_owner_q;
			pend_re_q   <= ram_rd[DELTA_BITS];
			ins_owner_q <= hd_owner_q;
			// repeating timer re-queued one period after its old deadline
			ins_dl_q    <= hd_dl_q + TIME_W'(period);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (result_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.fired_id  <= pend_id_q;
			out_q.fire_time <= now_q;
			out_q.rearmed   <= pend_re_q;
			out_q.last      <= emit_last;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

endmodule
